// ===== src/assert_macros.svh =====
// Assertion helpers used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/lz4d_pkg.sv =====
`default_nettype none
package lz4d_pkg;

    localparam int HistAddrBits = 16;
    localparam int CountBits    = 32;

    typedef logic [HistAddrBits-1:0] hist_addr_t;
    typedef logic [CountBits-1:0]    count_t;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_PRELOAD = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_BYTE  = 2'd1,
        ST_DONE  = 2'd2,
        ST_ERROR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_TOKEN    = 3'd0,
        PH_LITLEN   = 3'd1,
        PH_LITS     = 3'd2,
        PH_OFFLO    = 3'd3,
        PH_OFFHI    = 3'd4,
        PH_MATCHLEN = 3'd5,
        PH_COPY     = 3'd6
    } phase_t;

    // Result beat waiting in the output stage.
    typedef struct packed {
        logic [CountBits-1:0] bytes_written;
        logic [CountBits-1:0] match_left;
        logic [7:0]           out_byte;
        status_t              status;
    } result_t;

endpackage
`default_nettype wire

// ===== src/lz4d_hist_ram.sv =====
`default_nettype none
module lz4d_hist_ram (
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire lz4d_pkg::hist_addr_t    wr_addr,
    input  wire logic [7:0]              wr_data,
    input  wire lz4d_pkg::hist_addr_t    rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] mem [0:(1 << lz4d_pkg::HistAddrBits)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/lz4_block_decoder.sv =====
// LZ4 block decoder.
// s_axis carries one item per beat: tdata = data_byte, tlast = last of the
// block, tuser = op. Op 0 feeds one compressed byte, op 1 is a copy tick that
// releases one match byte, op 2 preloads one dictionary byte before a block
// starts.
// m_axis returns exactly one result beat per accepted item: tuser = status,
// tdata = out_byte, match_left and bytes_written.
// cfg writes output_capacity; write it only while the block is idle.
// A result is registered in stage 1 and then in the output register. The
// history is a 64 KiB single-write, single-read RAM with a registered read;
// a copy tick reads it in the accept cycle and the byte is written back in
// the following cycle, so a match byte at distance one is forwarded from the
// write stage. Throughput is one item per cycle while the receiver takes
// results, set by the RAM port. Reset clears all parse state; history is
// not cleared (only bytes written during the current block are ever read).
// When the receiver stalls, the output register holds and s_axis_tready
// drops once the result stage is full.
`default_nettype none
`include "assert_macros.svh"
module lz4_block_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tlast,
    input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0], match_left[39:8], bytes_written[71:40]
    output logic [71:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int CB = lz4d_pkg::CountBits;
    localparam int AB = lz4d_pkg::HistAddrBits;

    typedef logic [CB:0] wide_t;

    lz4d_pkg::count_t     cap_reg;
    lz4d_pkg::phase_t     phase_reg, phase_next;
    lz4d_pkg::hist_addr_t wp_reg, wp_next;
    lz4d_pkg::count_t     prod_reg, prod_next;
    lz4d_pkg::count_t     pref_reg, pref_next;
    lz4d_pkg::count_t     lit_reg, lit_next;
    lz4d_pkg::count_t     copy_reg, copy_next;
    lz4d_pkg::hist_addr_t dist_reg, dist_next;
    logic [3:0]           nib_reg, nib_next;
    logic [7:0]           offlo_reg, offlo_next;

    // Stage 1: item accepted; a copy tick waits for RAM data here.
    logic                 s1_valid_reg;
    logic                 s1_copy_reg;
    lz4d_pkg::result_t    s1_res_reg;
    lz4d_pkg::hist_addr_t s1_waddr_reg;
    logic                 s1_fwd_reg;
    lz4d_pkg::result_t    s1_view;

    // Write stage kept for forwarding.
    logic                 w_en_reg;
    lz4d_pkg::hist_addr_t w_addr_reg;
    logic [7:0]           w_data_reg;

    // Output stage.
    logic                 out_valid_reg;
    lz4d_pkg::result_t    out_res_reg;

    logic [7:0]           rd_data;
    logic [7:0]           copy_byte;
    logic                 acc, advance, s1_free;
    logic [1:0]           op;
    logic [7:0]           b;
    logic                 last;
    lz4d_pkg::result_t    res;
    logic                 restart, ram_we, is_copy;
    lz4d_pkg::hist_addr_t ram_waddr, rd_addr;
    logic [7:0]           ram_wdata;
    lz4d_pkg::count_t     held, room;
    wide_t                sum_w;
    lz4d_pkg::count_t     len;
    logic [AB:0]          dist_w;

    assign op   = s_axis_tuser;
    assign b    = s_axis_tdata;
    assign last = s_axis_tlast;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s1_free       = !s1_valid_reg || advance;
    assign s_axis_tready = s1_free;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign held = pref_reg + prod_reg;
    assign room = (cap_reg > held) ? (cap_reg - held) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        wp_next    = wp_reg;
        prod_next  = prod_reg;
        pref_next  = pref_reg;
        lit_next   = lit_reg;
        copy_next  = copy_reg;
        dist_next  = dist_reg;
        nib_next   = nib_reg;
        offlo_next = offlo_reg;
        res        = '0;
        restart    = 1'b0;
        ram_we     = 1'b0;
        ram_wdata  = b;
        is_copy    = 1'b0;
        sum_w      = '0;
        len        = '0;
        dist_w     = '0;
        if (acc)
        begin
            case (op)
                lz4d_pkg::OP_BYTE:
                begin
                    case (phase_reg)
                        lz4d_pkg::PH_TOKEN:
                        begin
                            nib_next = b[3:0];
                            len      = CB'(b[7:4]);
                            if (b[7:4] == 4'hf)
                            begin
                                lit_next = CB'(15);
                                if (last) res.status = lz4d_pkg::ST_ERROR;
                                else phase_next = lz4d_pkg::PH_LITLEN;
                            end
                            else if (len > room) res.status = lz4d_pkg::ST_ERROR;
                            else if (b[7:4] == 4'h0)
                            begin
                                if (last)
                                begin
                                    res.status        = lz4d_pkg::ST_DONE;
                                    res.bytes_written = prod_reg;
                                    restart           = 1'b1;
                                end
                                else phase_next = lz4d_pkg::PH_OFFLO;
                            end
                            else if (last) res.status = lz4d_pkg::ST_ERROR;
                            else
                            begin
                                lit_next   = len;
                                phase_next = lz4d_pkg::PH_LITS;
                            end
                        end
                        lz4d_pkg::PH_LITLEN:
                        begin
                            sum_w    = {1'b0, lit_reg} + wide_t'(b);
                            lit_next = sum_w[CB-1:0];
                            if (sum_w[CB] || last) res.status = lz4d_pkg::ST_ERROR;
                            else if (b != 8'hff)
                            begin
                                if (sum_w[CB-1:0] > room) res.status = lz4d_pkg::ST_ERROR;
                                else phase_next = lz4d_pkg::PH_LITS;
                            end
                        end
                        lz4d_pkg::PH_LITS:
                        begin
                            ram_we       = 1'b1;
                            wp_next      = wp_reg + 1'b1;
                            prod_next    = prod_reg + 1'b1;
                            lit_next     = lit_reg - 1'b1;
                            res.out_byte = b;
                            res.status   = lz4d_pkg::ST_BYTE;
                            if (lit_reg == CB'(1))
                            begin
                                if (last)
                                begin
                                    res.status        = lz4d_pkg::ST_DONE;
                                    res.bytes_written = prod_reg + 1'b1;
                                    restart           = 1'b1;
                                end
                                else phase_next = lz4d_pkg::PH_OFFLO;
                            end
                            else if (last)
                            begin
                                res.status   = lz4d_pkg::ST_ERROR;
                                res.out_byte = '0;
                            end
                        end
                        lz4d_pkg::PH_OFFLO:
                        begin
                            offlo_next = b;
                            if (last) res.status = lz4d_pkg::ST_ERROR;
                            else phase_next = lz4d_pkg::PH_OFFHI;
                        end
                        lz4d_pkg::PH_OFFHI:
                        begin
                            dist_w    = {1'b0, b, offlo_reg};
                            dist_next = dist_w[AB-1:0];
                            len       = CB'(nib_reg) + CB'(4);
                            if (dist_w == '0 || CB'(dist_w) > held || last)
                                res.status = lz4d_pkg::ST_ERROR;
                            else if (nib_reg == 4'hf)
                            begin
                                copy_next  = CB'(15);
                                phase_next = lz4d_pkg::PH_MATCHLEN;
                            end
                            else if (len > room) res.status = lz4d_pkg::ST_ERROR;
                            else
                            begin
                                copy_next  = len;
                                phase_next = lz4d_pkg::PH_COPY;
                            end
                        end
                        lz4d_pkg::PH_MATCHLEN:
                        begin
                            sum_w     = {1'b0, copy_reg} + wide_t'(b);
                            copy_next = sum_w[CB-1:0];
                            len       = sum_w[CB-1:0] + CB'(4);
                            if (sum_w[CB] || last) res.status = lz4d_pkg::ST_ERROR;
                            else if (b != 8'hff)
                            begin
                                // The final length adds four; it must still fit the counter.
                                if (sum_w[CB-1:0] > {CB{1'b1}} - CB'(4))
                                    res.status = lz4d_pkg::ST_ERROR;
                                else if (len > room) res.status = lz4d_pkg::ST_ERROR;
                                else
                                begin
                                    copy_next  = len;
                                    phase_next = lz4d_pkg::PH_COPY;
                                end
                            end
                        end
                        default: res.status = lz4d_pkg::ST_ERROR;
                    endcase
                end
                lz4d_pkg::OP_TICK:
                begin
                    if (phase_reg == lz4d_pkg::PH_COPY)
                    begin
                        is_copy    = 1'b1;
                        wp_next    = wp_reg + 1'b1;
                        prod_next  = prod_reg + 1'b1;
                        copy_next  = copy_reg - 1'b1;
                        res.status = lz4d_pkg::ST_BYTE;
                        if (copy_reg == CB'(1)) phase_next = lz4d_pkg::PH_TOKEN;
                    end
                end
                lz4d_pkg::OP_PRELOAD:
                begin
                    if (phase_reg == lz4d_pkg::PH_TOKEN && prod_reg == '0 && room != '0)
                    begin
                        ram_we    = 1'b1;
                        wp_next   = wp_reg + 1'b1;
                        pref_next = pref_reg + 1'b1;
                    end
                    else res.status = lz4d_pkg::ST_ERROR;
                end
                default: ;
            endcase
            if (res.status == lz4d_pkg::ST_ERROR) restart = 1'b1;
            if (restart)
            begin
                phase_next = lz4d_pkg::PH_TOKEN;
                wp_next    = '0;
                prod_next  = '0;
                pref_next  = '0;
                lit_next   = '0;
                copy_next  = '0;
                dist_next  = '0;
                nib_next   = '0;
                offlo_next = '0;
            end
            res.match_left = (phase_next == lz4d_pkg::PH_COPY) ? copy_next : '0;
        end
    end

    // Copy bytes are written in the same cycle that their read returns.
    assign copy_byte = s1_fwd_reg ? w_data_reg : rd_data;
    assign rd_addr   = wp_reg - dist_reg;
    assign ram_waddr = (s1_valid_reg && s1_copy_reg) ? s1_waddr_reg : wp_reg;

    // Stage 1 result with the copy byte filled in while it is on the RAM port.
    always_comb
    begin
        s1_view = s1_res_reg;
        if (s1_valid_reg && s1_copy_reg) s1_view.out_byte = copy_byte;
    end

    lz4d_hist_ram u_hist (
        .clk     (clk),
        .wr_en   (ram_we || (s1_valid_reg && s1_copy_reg)),
        .wr_addr (ram_waddr),
        .wr_data ((s1_valid_reg && s1_copy_reg) ? copy_byte : ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= '1;
            phase_reg     <= lz4d_pkg::PH_TOKEN;
            wp_reg        <= '0;
            prod_reg      <= '0;
            pref_reg      <= '0;
            lit_reg       <= '0;
            copy_reg      <= '0;
            dist_reg      <= '0;
            nib_reg       <= '0;
            offlo_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s1_copy_reg   <= 1'b0;
            w_en_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            prod_reg  <= prod_next;
            pref_reg  <= pref_next;
            lit_reg   <= lit_next;
            copy_reg  <= copy_next;
            dist_reg  <= dist_next;
            nib_reg   <= nib_next;
            offlo_reg <= offlo_next;
            w_en_reg  <= s1_valid_reg && s1_copy_reg;
            if (advance) out_valid_reg <= s1_valid_reg;
            if (s1_free)
            begin
                s1_valid_reg <= acc;
                s1_copy_reg  <= acc && is_copy;
            end
            else
            begin
                // Hold; the copy byte is already written.
                s1_copy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_addr_reg <= s1_waddr_reg;
        w_data_reg <= copy_byte;
        if (s1_free)
        begin
            s1_res_reg   <= res;
            s1_waddr_reg <= wp_reg;
            // Distance one reads the entry still being written this cycle.
            s1_fwd_reg   <= s1_valid_reg && s1_copy_reg && (rd_addr == s1_waddr_reg);
        end
        else
        begin
            s1_res_reg <= s1_view;
        end
        if (advance)
        begin
            out_res_reg <= s1_view;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.bytes_written, out_res_reg.match_left,
                            out_res_reg.out_byte};
    assign m_axis_tuser  = out_res_reg.status;

    `ASSERT_IMPLY(a_copy_only_in_match, clk, rst_n,
        acc && is_copy, phase_reg == lz4d_pkg::PH_COPY,
        "copy issued outside a match")
    `ASSERT_IMPLY(a_out_holds, clk, rst_n,
        $past(out_valid_reg && !m_axis_tready), out_valid_reg,
        "result lost under stall")
    `ASSERT_NEVER(a_wr_clash, clk, rst_n,
        ram_we && s1_valid_reg && s1_copy_reg,
        "two history writes in one cycle")
    `ASSERT_IMPLY(a_fwd_addr, clk, rst_n,
        w_en_reg && s1_fwd_reg && s1_valid_reg && s1_copy_reg,
        w_addr_reg + 1'b1 == s1_waddr_reg,
        "forward from wrong entry")

endmodule
`default_nettype wire

// ===== dv/tb_lz4_block_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_lz4_block_decoder;
    import lz4d_pkg::*;

    localparam logic [63:0] CMAX = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_ITEMS = 250;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte[7:0]
    logic        s_axis_tlast;
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // out_byte[7:0], match_left[39:8], bytes_written[71:40]
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;   // status[1:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    lz4_block_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Decoder shadow state
    logic [7:0]  hist_mem [0:65535];
    logic [15:0] wr_ptr;
    logic [63:0] out_count;
    logic [63:0] pre_count;
    phase_t      phase;
    logic [63:0] lit_rem;
    logic [63:0] copy_rem;
    logic [15:0] match_dist;
    logic [3:0]  mnib;
    logic [7:0]  off_lo;
    logic [31:0] capacity;

    result_t     expected_q[$];
    int          error_count;
    int          item_count;
    int          n_done;
    int          n_err;
    int          n_bytes;
    int          cycles;
    bit          idle_en;
    int          rx_stall;

    function automatic void restart_block();
        wr_ptr   = '0;
        out_count = '0;
        pre_count = '0;
        phase    = PH_TOKEN;
        lit_rem  = '0;
        copy_rem = '0;
        match_dist = '0;
        mnib     = '0;
        off_lo   = '0;
    endfunction

    function automatic logic [63:0] held_cnt();
        return (pre_count + out_count) & CMAX;
    endfunction

    function automatic logic [63:0] room_left();
        logic [63:0] h;
        h = held_cnt();
        return ({32'd0, capacity} > h) ? {32'd0, capacity} - h : 64'd0;
    endfunction

    function automatic void abort_block(inout status_t st);
        st = ST_ERROR;
        restart_block();
    endfunction

    function automatic void put_hist(input logic [7:0] b);
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 16'd1;
    endfunction

    function automatic void start_match(input logic [63:0] len, inout status_t st);
        if (len > room_left())
            abort_block(st);
        else
        begin
            copy_rem = len;
            phase = PH_COPY;
        end
    endfunction

    function automatic void decode_step(input op_t op, input logic [7:0] b, input bit last,
                                        output result_t r);
        status_t     st;
        logic [7:0]  ob;
        logic [63:0] bw;
        logic [63:0] lit;
        logic [15:0] d;
        st = ST_NONE;
        ob = '0;
        bw = '0;
        case (op)
            OP_BYTE:
                if (phase == PH_COPY)
                    abort_block(st);
                else
                    case (phase)
                        PH_TOKEN:
                        begin
                            lit = {60'd0, b[7:4]};
                            mnib = b[3:0];
                            if (lit == 64'd15)
                            begin
                                lit_rem = 64'd15;
                                if (last) abort_block(st);
                                else phase = PH_LITLEN;
                            end
                            else if (lit > room_left())
                                abort_block(st);
                            else if (lit == 64'd0)
                            begin
                                if (last)
                                begin
                                    bw = out_count;
                                    restart_block();
                                    st = ST_DONE;
                                end
                                else
                                    phase = PH_OFFLO;
                            end
                            else if (last)
                                abort_block(st);
                            else
                            begin
                                lit_rem = lit;
                                phase = PH_LITS;
                            end
                        end
                        PH_LITLEN:
                            if ({56'd0, b} > CMAX - lit_rem)
                                abort_block(st);
                            else
                            begin
                                lit_rem = lit_rem + {56'd0, b};
                                if (last) abort_block(st);
                                else if (b != 8'hFF)
                                begin
                                    if (lit_rem > room_left()) abort_block(st);
                                    else phase = PH_LITS;
                                end
                            end
                        PH_LITS:
                        begin
                            put_hist(b);
                            out_count = (out_count + 64'd1) & CMAX;
                            lit_rem = lit_rem - 64'd1;
                            if (lit_rem == 64'd0)
                            begin
                                ob = b;
                                if (last)
                                begin
                                    bw = out_count;
                                    restart_block();
                                    st = ST_DONE;
                                end
                                else
                                begin
                                    phase = PH_OFFLO;
                                    st = ST_BYTE;
                                end
                            end
                            else if (last)
                                abort_block(st);
                            else
                            begin
                                ob = b;
                                st = ST_BYTE;
                            end
                        end
                        PH_OFFLO:
                        begin
                            off_lo = b;
                            if (last) abort_block(st);
                            else phase = PH_OFFHI;
                        end
                        PH_OFFHI:
                        begin
                            d = {b, off_lo};
                            if (d == 16'd0 || {48'd0, d} > held_cnt())
                                abort_block(st);
                            else
                            begin
                                match_dist = d;
                                if (last) abort_block(st);
                                else if (mnib == 4'd15)
                                begin
                                    copy_rem = 64'd15;
                                    phase = PH_MATCHLEN;
                                end
                                else
                                    start_match({60'd0, mnib} + 64'd4, st);
                            end
                        end
                        PH_MATCHLEN:
                            if ({56'd0, b} > CMAX - copy_rem)
                                abort_block(st);
                            else
                            begin
                                copy_rem = copy_rem + {56'd0, b};
                                if (last) abort_block(st);
                                else if (b != 8'hFF)
                                begin
                                    if (copy_rem > CMAX - 64'd4) abort_block(st);
                                    else start_match(copy_rem + 64'd4, st);
                                end
                            end
                        default: abort_block(st);
                    endcase
            OP_TICK:
                if (phase == PH_COPY)
                begin
                    ob = hist_mem[wr_ptr - match_dist];
                    put_hist(ob);
                    out_count = (out_count + 64'd1) & CMAX;
                    copy_rem = copy_rem - 64'd1;
                    if (copy_rem == 64'd0) phase = PH_TOKEN;
                    st = ST_BYTE;
                end
            OP_PRELOAD:
                if (phase == PH_TOKEN && out_count == 64'd0 && room_left() > 64'd0)
                begin
                    put_hist(b);
                    pre_count = (pre_count + 64'd1) & CMAX;
                end
                else
                    abort_block(st);
            default: ;
        endcase
        r.status = st;
        r.out_byte = ob;
        r.match_left = (phase == PH_COPY) ? copy_rem[31:0] : 32'd0;
        r.bytes_written = (st == ST_DONE) ? bw[31:0] : 32'd0;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(input op_t op, input logic [7:0] b, input bit last);
        result_t r;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_step(op, b, last, r);
        expected_q.push_back(r);
        item_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, want %0h (item region %0d)", what, got, want,
                 item_count);
        error_count++;
    endtask

    // Length field: nibble saturates at 15, the rest goes in 255-continued bytes.
    task automatic send_ext(input int rem);
        while (rem >= 255)
        begin
            send_item(OP_BYTE, 8'hFF, 1'b0);
            rem -= 255;
        end
        send_item(OP_BYTE, rem[7:0], 1'b0);
    endtask

    task automatic drain_ticks();
        int guard;
        guard = 0;
        while (phase == PH_COPY && guard < 400)
        begin
            send_item(OP_TICK, 8'($urandom()), 1'($urandom_range(0, 1)));
            guard++;
        end
    endtask

    function automatic int pick_len(input int lo);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return lo + $urandom_range(250, 300);
        if (k < 4) return lo + $urandom_range(15, 40);
        return lo + $urandom_range(0, 6);
    endfunction

    task automatic send_block();
        int nseq;
        int lit;
        int mlen;
        int h;
        logic [15:0] d;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                send_item(OP_PRELOAD, 8'($urandom()), 1'($urandom_range(0, 1)));
        nseq = $urandom_range(1, 4);
        for (int s = 0; s <= nseq; s++)
        begin
            lit = pick_len(0);
            if (s < nseq && held_cnt() == 0 && lit == 0) lit = 1;
            if (s == nseq)
            begin
                // closing sequence: literals only, last on the final byte
                if (lit == 0)
                begin
                    send_item(OP_BYTE, {4'd0, 4'($urandom())}, 1'b1);
                    return;
                end
                send_item(OP_BYTE, {(lit >= 15 ? 4'd15 : 4'(lit)), 4'($urandom())}, 1'b0);
                if (lit >= 15) send_ext(lit - 15);
                for (int i = 0; i < lit; i++)
                    send_item(OP_BYTE, 8'($urandom()), i == lit - 1);
                return;
            end
            mlen = pick_len(4);
            send_item(OP_BYTE, {(lit >= 15 ? 4'd15 : 4'(lit)),
                                (mlen - 4 >= 15 ? 4'd15 : 4'(mlen - 4))}, 1'b0);
            if (lit >= 15) send_ext(lit - 15);
            for (int i = 0; i < lit; i++)
                send_item(OP_BYTE, 8'($urandom()), 1'b0);
            h = held_cnt() > 65535 ? 65535 : int'(held_cnt());
            if (h == 0 || $urandom_range(0, 15) == 0)
                d = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'(h + 1);
            else if ($urandom_range(0, 2) == 0)
                d = 16'($urandom_range(1, h < 4 ? h : 4));
            else
                d = 16'($urandom_range(1, h));
            send_item(OP_BYTE, d[7:0], 1'b0);
            send_item(OP_BYTE, d[15:8], 1'b0);
            if (mlen - 4 >= 15) send_ext(mlen - 19);
            drain_ticks();
        end
    endtask

    task automatic test_literals_and_overlap();
        send_item(OP_PRELOAD, 8'h00, 1'b0);
        send_item(OP_PRELOAD, 8'hFF, 1'b1);
        send_item(OP_BYTE, 8'h21, 1'b0);
        send_item(OP_BYTE, 8'hFF, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h01, 1'b0);   // distance one: overlapping copy
        send_item(OP_BYTE, 8'h00, 1'b0);
        drain_ticks();
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_TICK, 8'hA5, 1'b0);   // tick with nothing pending
        send_item(OP_NONE, 8'h5A, 1'b1);
    endtask

    task automatic test_error_cases();
        send_item(OP_BYTE, 8'h10, 1'b1);   // truncated literal run
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);   // offset zero
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_BYTE, 8'h61, 1'b0);
        send_item(OP_BYTE, 8'h01, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);   // block ends right after match header
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_BYTE, 8'h62, 1'b0);
        send_item(OP_BYTE, 8'h01, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h33, 1'b0);   // byte while a match is pending
        send_item(OP_BYTE, 8'h20, 1'b0);
        send_item(OP_PRELOAD, 8'h44, 1'b0); // preload after block start
    endtask

    task automatic test_capacity();
        write_capacity(32'd0);
        send_item(OP_PRELOAD, 8'h11, 1'b0);
        send_item(OP_BYTE, 8'h10, 1'b0);
        write_capacity(32'd3);
        send_item(OP_PRELOAD, 8'h22, 1'b0);
        send_item(OP_PRELOAD, 8'h33, 1'b0);
        send_item(OP_BYTE, 8'h20, 1'b0);   // two literals, one byte of room
        send_item(OP_BYTE, 8'hF0, 1'b0);
        send_item(OP_BYTE, 8'hFF, 1'b0);
        send_item(OP_BYTE, 8'h01, 1'b0);
        write_capacity(32'd1000);
        repeat (3) send_block();
        // drop the limit under what a pending block already holds
        send_item(OP_BYTE, 8'h30, 1'b0);
        repeat (3) send_item(OP_BYTE, 8'($urandom()), 1'b0);
        write_capacity(32'd2);
        send_item(OP_BYTE, 8'h10, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        write_capacity(32'($urandom_range(40, 5000)));
        repeat (3) send_block();
    endtask

    task automatic send_random_chunk();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_item(op_t'($urandom_range(0, 3)), 8'($urandom()),
                          1'($urandom_range(0, 1)));
        else
            send_block();
    endtask

    task automatic test_random_stream();
        int start;
        while (item_count < ITEM_TARGET - QUIET_ITEMS)
            send_random_chunk();
        // final stretch runs with no idling on either side
        idle_en = 1'b0;
        start = item_count;
        while (item_count - start < QUIET_ITEMS)
            send_random_chunk();
    endtask

    always @(negedge clk)
    begin
        if (idle_en && rx_stall == 0 && $urandom_range(0, 7) == 0)
            rx_stall = $urandom_range(1, 7);
        if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tuser != e.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(e.status));
                if (m_axis_tdata[7:0] != e.out_byte)
                    report_mismatch("out_byte", 32'(m_axis_tdata[7:0]), 32'(e.out_byte));
                if (m_axis_tdata[39:8] != e.match_left)
                    report_mismatch("match_left", m_axis_tdata[39:8], e.match_left);
                if (m_axis_tdata[71:40] != e.bytes_written)
                    report_mismatch("bytes_written", m_axis_tdata[71:40], e.bytes_written);
                if (e.status == ST_DONE) n_done++;
                if (e.status == ST_ERROR) n_err++;
                if (e.status == ST_BYTE) n_bytes++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_lz4_block_decoder: done, errors");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        error_count = 0;
        item_count = 0;
        n_done = 0;
        n_err = 0;
        n_bytes = 0;
        rx_stall = 0;
        idle_en = 1'b1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = '0;
        capacity = 32'hFFFF_FFFF;
        restart_block();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_capacity(32'hFFFF_FFFF);
        test_literals_and_overlap();
        test_error_cases();
        test_capacity();
        write_capacity(32'hFFFF_FFFF);
        test_random_stream();

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("covered %0d items: %0d decoded bytes, %0d blocks done, %0d errors flagged",
                 item_count, n_bytes, n_done, n_err);
        $display("capacity settings swept from 0 through small limits to all ones");
        if (error_count == 0)
            $display("tb_lz4_block_decoder: done, clean");
        else
            $display("tb_lz4_block_decoder: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== lz4_block_decoder.f =====
+incdir+src
src/lz4d_pkg.sv
src/lz4d_hist_ram.sv
src/lz4_block_decoder.sv
dv/tb_lz4_block_decoder.sv
